// File: rtl/bbpe_pkg.sv
`default_nettype none
package bbpe_pkg;

   localparam int COORD_W    = 24;
   localparam int PARAM_W    = 17;
   localparam int COUNT_W    = 4;
   localparam int BERN_W     = 17;
   localparam int SQ_W       = 34;
   localparam int WEIGHT_W   = 33;
   localparam int PROD_W     = 58;
   localparam int ACC_W      = 60;
   localparam int STEP_W     = 4;

   localparam logic [PARAM_W-1:0] ONE_Q16 = 17'h10000;

   localparam logic [STEP_W-1:0] WEIGHT_LAST = 4'd11;
   localparam logic [STEP_W-1:0] MAC_LAST    = 4'd15;
   localparam logic [STEP_W-1:0] DRAIN_LAST  = 4'd1;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOCATE,
      ST_WEIGHT,
      ST_MAC,
      ST_DRAIN,
      ST_FINISH
   } ctl_state_type;

   typedef enum logic [2:0] {
      W_SQ_S,
      W_SQ_T,
      W_B0,
      W_B1,
      W_B2,
      W_B3
   } w_op_type;

   typedef struct packed {
      logic              capture;
      logic              locate;
      logic              wen;
      logic              wdir;
      w_op_type          wop;
      logic              mac_en;
      logic [STEP_W-1:0] mac_idx;
      logic              out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic out_full;
   } dp_status_type;

endpackage
`default_nettype wire

// File: rtl/bicubic_bezier_patch_evaluator.sv
// an evaluate word steps through locate, weight, mac, drain and finish states; its
//    result is registered once the output is free; no word is taken until it is done
//    (12 weight steps on one multiplier, 16 store reads); loads do not stall
// reset: synchronous, active high; patch_count returns to 1, store contents undefined
`default_nettype none
module bicubic_bezier_patch_evaluator #(
   parameter int MAX_PATCHES = 8
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire                                req_command,
   input  wire [2:0]                          req_patch_row,
   input  wire [2:0]                          req_patch_col,
   input  wire [1:0]                          req_point_row,
   input  wire [1:0]                          req_point_col,
   input  wire signed [bbpe_pkg::COORD_W-1:0] req_coord_x,
   input  wire signed [bbpe_pkg::COORD_W-1:0] req_coord_y,
   input  wire signed [bbpe_pkg::COORD_W-1:0] req_coord_z,
   input  wire [bbpe_pkg::PARAM_W-1:0]        req_param_u,
   input  wire [bbpe_pkg::PARAM_W-1:0]        req_param_v,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic signed [bbpe_pkg::COORD_W-1:0] rsp_surf_x,
   output logic signed [bbpe_pkg::COORD_W-1:0] rsp_surf_y,
   output logic signed [bbpe_pkg::COORD_W-1:0] rsp_surf_z,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire [bbpe_pkg::COUNT_W-1:0]        csr_patch_count
);
   import bbpe_pkg::*;

   logic [COUNT_W-1:0] patch_count_ff;
   dp_cmd_type         cmd;
   dp_status_type      status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) patch_count_ff <= COUNT_W'(1);
      else if (csr_valid && csr_ready) patch_count_ff <= csr_patch_count;
   end

   bbpe_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   bbpe_datapath #(.MAX_PATCHES(MAX_PATCHES)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .patch_count   (patch_count_ff),
      .req_command   (req_command),
      .req_patch_row (req_patch_row),
      .req_patch_col (req_patch_col),
      .req_point_row (req_point_row),
      .req_point_col (req_point_col),
      .req_coord_x   (req_coord_x),
      .req_coord_y   (req_coord_y),
      .req_coord_z   (req_coord_z),
      .req_param_u   (req_param_u),
      .req_param_v   (req_param_v),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_surf_x    (rsp_surf_x),
      .rsp_surf_y    (rsp_surf_y),
      .rsp_surf_z    (rsp_surf_z)
   );

`ifndef SYNTHESIS
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == CMD_EVAL |=> req_stall)
      else $error("evaluate word did not start work");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == CMD_LOAD |=> !req_stall)
      else $error("load word blocked the input");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.out_load))
      else $error("result appeared without a finish");
`endif

endmodule
`default_nettype wire

// File: rtl/bbpe_ctrl.sv
`default_nettype none
module bbpe_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   req_command,
   output logic                  req_stall,
   input  wire                   rsp_stall,
   input  bbpe_pkg::dp_status_type status,
   output bbpe_pkg::dp_cmd_type  cmd
);
   import bbpe_pkg::*;

   ctl_state_type     state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              out_free;

   assign out_free = !status.out_full || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid && req_command == CMD_EVAL) state_in = ST_LOCATE;
         end
         ST_LOCATE: begin
            state_in = ST_WEIGHT;
            cnt_in   = '0;
         end
         ST_WEIGHT: begin
            if (cnt_ff == WEIGHT_LAST) begin
               state_in = ST_MAC;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MAC: begin
            if (cnt_ff == MAC_LAST) begin
               state_in = ST_DRAIN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (cnt_ff == DRAIN_LAST) begin
               state_in = ST_FINISH;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      cmd          = '0;
      cmd.wop      = W_SQ_S;
      cmd.capture  = (state_ff == ST_IDLE) && req_valid;
      cmd.locate   = (state_ff == ST_LOCATE);
      cmd.mac_en   = (state_ff == ST_MAC);
      cmd.mac_idx  = cnt_ff;
      cmd.out_load = (state_ff == ST_FINISH) && out_free;
      if (state_ff == ST_WEIGHT) begin
         cmd.wen  = 1'b1;
         cmd.wdir = (cnt_ff > 4'd5);
         unique case (cnt_ff)
            4'd0, 4'd6:  cmd.wop = W_SQ_S;
            4'd1, 4'd7:  cmd.wop = W_SQ_T;
            4'd2, 4'd8:  cmd.wop = W_B0;
            4'd3, 4'd9:  cmd.wop = W_B1;
            4'd4, 4'd10: cmd.wop = W_B2;
            default:     cmd.wop = W_B3;
         endcase
      end
   end

endmodule
`default_nettype wire

// File: rtl/bbpe_datapath.sv
`default_nettype none
module bbpe_datapath #(
   parameter int MAX_PATCHES = 8
) (
   input  wire                              clock,
   input  wire                              reset,
   input  bbpe_pkg::dp_cmd_type             cmd,
   output bbpe_pkg::dp_status_type          status,
   input  wire [bbpe_pkg::COUNT_W-1:0]      patch_count,
   input  wire                              req_command,
   input  wire [2:0]                        req_patch_row,
   input  wire [2:0]                        req_patch_col,
   input  wire [1:0]                        req_point_row,
   input  wire [1:0]                        req_point_col,
   input  wire signed [bbpe_pkg::COORD_W-1:0] req_coord_x,
   input  wire signed [bbpe_pkg::COORD_W-1:0] req_coord_y,
   input  wire signed [bbpe_pkg::COORD_W-1:0] req_coord_z,
   input  wire [bbpe_pkg::PARAM_W-1:0]      req_param_u,
   input  wire [bbpe_pkg::PARAM_W-1:0]      req_param_v,
   input  wire                              rsp_stall,
   output logic                             rsp_valid,
   output logic signed [bbpe_pkg::COORD_W-1:0] rsp_surf_x,
   output logic signed [bbpe_pkg::COORD_W-1:0] rsp_surf_y,
   output logic signed [bbpe_pkg::COORD_W-1:0] rsp_surf_z
);
   import bbpe_pkg::*;

   localparam int IDX_W  = (MAX_PATCHES > 1) ? $clog2(MAX_PATCHES) : 1;
   localparam int DEPTH  = MAX_PATCHES * MAX_PATCHES * 16;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int N_W    = $clog2(MAX_PATCHES + 1) + 1;
   localparam logic [N_W-1:0] N_MAX = N_W'(MAX_PATCHES);

   logic [3*COORD_W-1:0] store_mem [DEPTH];

   logic [PARAM_W-1:0] u_ff, v_ff;
   logic [IDX_W-1:0]   ui_ff, vi_ff;
   logic [PARAM_W-1:0] tu_ff, tv_ff;
   logic [SQ_W-1:0]    sq_s_ff, sq_t_ff;
   logic [BERN_W-1:0]  bu_ff [4];
   logic [BERN_W-1:0]  bv_ff [4];
   logic [3*COORD_W-1:0] rd_ff;
   logic [WEIGHT_W-1:0]  w_ff;
   logic                 v1_ff, v2_ff;
   logic signed [PROD_W-1:0] prod_ff [3];
   logic signed [ACC_W-1:0]  acc_ff [3];
   logic                 rsp_valid_ff;
   logic signed [COORD_W-1:0] out_ff [3];

   logic [N_W-1:0]     n_eff;
   logic [IDX_W-1:0]   ui_in, vi_in;
   logic [PARAM_W-1:0] tu_in, tv_in;
   logic [PARAM_W-1:0] t_sel, s_sel;
   logic [SQ_W-1:0]    mul_a;
   logic [PARAM_W-1:0] mul_b;
   logic [SQ_W+PARAM_W-1:0] mul_p;
   logic [SQ_W+PARAM_W+1:0] mul_r;
   logic [BERN_W-1:0]  bern;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic               wr_en;
   logic signed [COORD_W-1:0] fin [3];

   function automatic logic [IDX_W+PARAM_W-1:0] locate(
      input logic [PARAM_W-1:0] raw,
      input logic [N_W-1:0]     n
   );
      logic [PARAM_W-1:0]       g;
      logic [PARAM_W+N_W-1:0]   p;
      logic [N_W+1:0]           q;
      logic [PARAM_W+N_W-1:0]   t;
      g = (raw > ONE_Q16) ? ONE_Q16 : raw;
      p = g * n;
      q = (N_W+2)'((p - 1'b1) >> 16);
      t = p - ((PARAM_W+N_W)'(q) << 16);
      if (g == '0) return '0;
      return {q[IDX_W-1:0], t[PARAM_W-1:0]};
   endfunction

   always_comb begin
      if (patch_count == '0) n_eff = N_W'(1);
      else if (N_W'(patch_count) > N_MAX) n_eff = N_MAX;
      else n_eff = N_W'(patch_count);
      {ui_in, tu_in} = locate(u_ff, n_eff);
      {vi_in, tv_in} = locate(v_ff, n_eff);
   end

   // bernstein weights through one shared multiplier
   always_comb begin
      t_sel = cmd.wdir ? tv_ff : tu_ff;
      s_sel = ONE_Q16 - t_sel;
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.wop)
         W_SQ_S: begin mul_a = SQ_W'(s_sel); mul_b = s_sel; end
         W_SQ_T: begin mul_a = SQ_W'(t_sel); mul_b = t_sel; end
         W_B0:   begin mul_a = sq_s_ff;      mul_b = s_sel; end
         W_B1:   begin mul_a = sq_s_ff;      mul_b = t_sel; end
         W_B2:   begin mul_a = sq_t_ff;      mul_b = s_sel; end
         default: begin mul_a = sq_t_ff;     mul_b = t_sel; end
      endcase
      mul_p = mul_a * mul_b;
      if (cmd.wop == W_B1 || cmd.wop == W_B2)
         mul_r = {1'b0, mul_p, 1'b0} + (SQ_W+PARAM_W+2)'(mul_p);
      else
         mul_r = (SQ_W+PARAM_W+2)'(mul_p);
      bern = BERN_W'((mul_r + (SQ_W+PARAM_W+2)'(64'h80000000)) >> 32);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture && req_command == CMD_EVAL) begin
         u_ff <= req_param_u;
         v_ff <= req_param_v;
      end
      if (cmd.locate) begin
         ui_ff <= ui_in;
         vi_ff <= vi_in;
         tu_ff <= tu_in;
         tv_ff <= tv_in;
      end
      if (cmd.wen) begin
         unique case (cmd.wop)
            W_SQ_S: sq_s_ff <= mul_p[SQ_W-1:0];
            W_SQ_T: sq_t_ff <= mul_p[SQ_W-1:0];
            W_B0: if (cmd.wdir) bv_ff[0] <= bern; else bu_ff[0] <= bern;
            W_B1: if (cmd.wdir) bv_ff[1] <= bern; else bu_ff[1] <= bern;
            W_B2: if (cmd.wdir) bv_ff[2] <= bern; else bu_ff[2] <= bern;
            default: if (cmd.wdir) bv_ff[3] <= bern; else bu_ff[3] <= bern;
         endcase
      end
   end

   // control point store
   assign wr_en = cmd.capture && req_command == CMD_LOAD
                  && (N_W'(req_patch_row) < N_MAX) && (N_W'(req_patch_col) < N_MAX);
   assign wr_addr = (ADDR_W'(req_patch_row) * ADDR_W'(MAX_PATCHES)
                     + ADDR_W'(req_patch_col)) * ADDR_W'(16)
                    + ADDR_W'({req_point_row, req_point_col});
   assign rd_addr = (ADDR_W'(vi_ff) * ADDR_W'(MAX_PATCHES) + ADDR_W'(ui_ff)) * ADDR_W'(16)
                    + ADDR_W'(cmd.mac_idx);

   always_ff @(posedge clock) begin
      if (wr_en) store_mem[wr_addr] <= {req_coord_x, req_coord_y, req_coord_z};
      if (cmd.mac_en) rd_ff <= store_mem[rd_addr];
   end

   // multiply-accumulate pipe
   always_ff @(posedge clock) begin
      if (cmd.mac_en)
         w_ff <= WEIGHT_W'(bv_ff[cmd.mac_idx[3:2]]) * WEIGHT_W'(bu_ff[cmd.mac_idx[1:0]]);
      for (int k = 0; k < 3; k++) begin
         prod_ff[k] <= $signed({1'b0, w_ff})
                       * $signed(rd_ff[(2-k)*COORD_W +: COORD_W]);
         if (cmd.locate) acc_ff[k] <= '0;
         else if (v2_ff) acc_ff[k] <= acc_ff[k] + ACC_W'(prod_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.mac_en;
         v2_ff <= v1_ff;
      end
   end

   // rounding and saturation
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [ACC_W-1:0] x;
         logic signed [ACC_W-33:0] q;
         x = acc_ff[k] + ACC_W'(64'sh80000000);
         q = (ACC_W-32)'(x >>> 32);
         if (q > (ACC_W-32)'(COORD_MAX)) fin[k] = COORD_MAX;
         else if (q < (ACC_W-32)'(COORD_MIN)) fin[k] = COORD_MIN;
         else fin[k] = COORD_W'(q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      if (cmd.out_load) begin
         for (int k = 0; k < 3; k++) out_ff[k] <= fin[k];
      end
   end

   assign status.out_full = rsp_valid_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_surf_x = out_ff[0];
   assign rsp_surf_y = out_ff[1];
   assign rsp_surf_z = out_ff[2];

endmodule
`default_nettype wire

// File: tb/bicubic_bezier_patch_evaluator_tb.sv
`default_nettype none
module bicubic_bezier_patch_evaluator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bbpe_pkg::*;

   localparam int GRID = 8;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int ITEMS_PER_PHASE = 315;

   typedef struct {
      logic                       cmd;
      logic [2:0]                 prow;
      logic [2:0]                 pcol;
      logic [1:0]                 pt_row;
      logic [1:0]                 pt_col;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
      logic signed [COORD_W-1:0]  z;
      logic [PARAM_W-1:0]         u;
      logic [PARAM_W-1:0]         v;
   } patch_word_type;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } surf_point_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_command = CMD_LOAD;
   logic [2:0] req_patch_row = '0;
   logic [2:0] req_patch_col = '0;
   logic [1:0] req_point_row = '0;
   logic [1:0] req_point_col = '0;
   logic signed [COORD_W-1:0] req_coord_x = '0;
   logic signed [COORD_W-1:0] req_coord_y = '0;
   logic signed [COORD_W-1:0] req_coord_z = '0;
   logic [PARAM_W-1:0] req_param_u = '0;
   logic [PARAM_W-1:0] req_param_v = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [COORD_W-1:0] rsp_surf_x;
   logic signed [COORD_W-1:0] rsp_surf_y;
   logic signed [COORD_W-1:0] rsp_surf_z;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [COUNT_W-1:0] csr_patch_count = '0;

   bicubic_bezier_patch_evaluator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_patch_row(req_patch_row), .req_patch_col(req_patch_col),
      .req_point_row(req_point_row), .req_point_col(req_point_col),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y), .req_coord_z(req_coord_z),
      .req_param_u(req_param_u), .req_param_v(req_param_v),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_surf_x(rsp_surf_x), .rsp_surf_y(rsp_surf_y), .rsp_surf_z(rsp_surf_z),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_patch_count(csr_patch_count)
   );

   patch_word_type pending_words[$];
   surf_point_type expected_points[$];
   patch_word_type held_word;
   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 15;
   int recv_idle_pct = 79;

   // predictor copy of the block
   logic signed [COORD_W-1:0] ctl_x[GRID*GRID*16];
   logic signed [COORD_W-1:0] ctl_y[GRID*GRID*16];
   logic signed [COORD_W-1:0] ctl_z[GRID*GRID*16];
   logic [COUNT_W-1:0] model_count = 4'd1;

   // generator view: which control points have been queued for loading
   bit gen_written[GRID*GRID*16];
   int gen_fill[GRID*GRID];
   int gen_count = 1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int effective_count(logic [COUNT_W-1:0] c);
      if (c == 0) return 1;
      if (c > GRID) return GRID;
      return int'(c);
   endfunction

   function automatic void locate_param(logic [PARAM_W-1:0] raw, int n,
                                        output int idx, output longint t);
      longint g;
      longint p;
      g = (raw > ONE_Q16) ? 65536 : raw;
      if (g == 0) begin
         idx = 0;
         t = 0;
      end else begin
         p = g * n;
         idx = int'((p + 65535) / 65536 - 1);
         t = p - longint'(idx) * 65536;
      end
   endfunction

   function automatic void bernstein(longint t, output longint b[4]);
      longint s;
      longint half;
      s = 65536 - t;
      half = 64'sd1 <<< 31;
      b[0] = (s * s * s + half) >>> 32;
      b[1] = (3 * s * s * t + half) >>> 32;
      b[2] = (3 * s * t * t + half) >>> 32;
      b[3] = (t * t * t + half) >>> 32;
   endfunction

   function automatic logic signed [COORD_W-1:0] round_sat(longint acc);
      longint q;
      q = (acc + (64'sd1 <<< 31)) >>> 32;
      if (q > 8388607) q = 8388607;
      if (q < -8388608) q = -8388608;
      return q[COORD_W-1:0];
   endfunction

   function automatic surf_point_type surface_at(logic [PARAM_W-1:0] u,
                                                 logic [PARAM_W-1:0] v);
      int n;
      int ui;
      int vi;
      int a;
      longint ut;
      longint vt;
      longint bu[4];
      longint bv[4];
      longint w;
      longint ax;
      longint ay;
      longint az;
      surf_point_type sp;
      n = effective_count(model_count);
      locate_param(u, n, ui, ut);
      locate_param(v, n, vi, vt);
      bernstein(ut, bu);
      bernstein(vt, bv);
      ax = 0;
      ay = 0;
      az = 0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            w = bv[r] * bu[c];
            a = (vi * GRID + ui) * 16 + r * 4 + c;
            ax += w * longint'(ctl_x[a]);
            ay += w * longint'(ctl_y[a]);
            az += w * longint'(ctl_z[a]);
         end
      end
      sp.x = round_sat(ax);
      sp.y = round_sat(ay);
      sp.z = round_sat(az);
      return sp;
   endfunction

   task automatic report(string msg);
      $display("mismatch: %s at cycle %0d", msg, cycles);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (held_word.cmd == CMD_LOAD) begin
               int a;
               a = (int'(held_word.prow) * GRID + int'(held_word.pcol)) * 16
                   + int'(held_word.pt_row) * 4 + int'(held_word.pt_col);
               ctl_x[a] = held_word.x;
               ctl_y[a] = held_word.y;
               ctl_z[a] = held_word.z;
            end else begin
               expected_points = {expected_points, surface_at(held_word.u, held_word.v)};
            end
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               held_word = pending_words.pop_front();
               req_command <= held_word.cmd;
               req_patch_row <= held_word.prow;
               req_patch_col <= held_word.pcol;
               req_point_row <= held_word.pt_row;
               req_point_col <= held_word.pt_col;
               req_coord_x <= held_word.x;
               req_coord_y <= held_word.y;
               req_coord_z <= held_word.z;
               req_param_u <= held_word.u;
               req_param_v <= held_word.v;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               report("unexpected result word");
            end else begin
               surf_point_type sp;
               sp = expected_points.pop_front();
               if (rsp_surf_x !== sp.x)
                  report($sformatf("surf_x expected %0d got %0d", sp.x, rsp_surf_x));
               if (rsp_surf_y !== sp.y)
                  report($sformatf("surf_y expected %0d got %0d", sp.y, rsp_surf_y));
               if (rsp_surf_z !== sp.z)
                  report($sformatf("surf_z expected %0d got %0d", sp.z, rsp_surf_z));
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic signed [COORD_W-1:0] rand_coord();
      if ($urandom_range(0, 1) == 0) return COORD_W'($urandom());
      return $signed(24'($urandom_range(0, 524287))) - 24'sd262144;
   endfunction

   task automatic queue_load(int prow, int pcol, int r, int c,
                             logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic signed [COORD_W-1:0] z);
      patch_word_type wd;
      int a;
      wd.cmd = CMD_LOAD;
      wd.prow = 3'(prow);
      wd.pcol = 3'(pcol);
      wd.pt_row = 2'(r);
      wd.pt_col = 2'(c);
      wd.x = x;
      wd.y = y;
      wd.z = z;
      wd.u = PARAM_W'($urandom());
      wd.v = PARAM_W'($urandom());
      pending_words = {pending_words, wd};
      a = (prow * GRID + pcol) * 16 + r * 4 + c;
      if (!gen_written[a]) begin
         gen_written[a] = 1'b1;
         gen_fill[prow * GRID + pcol]++;
      end
   endtask

   task automatic queue_eval(logic [PARAM_W-1:0] u, logic [PARAM_W-1:0] v);
      patch_word_type wd;
      wd.cmd = CMD_EVAL;
      wd.prow = 3'($urandom());
      wd.pcol = 3'($urandom());
      wd.pt_row = 2'($urandom());
      wd.pt_col = 2'($urandom());
      wd.x = COORD_W'($urandom());
      wd.y = COORD_W'($urandom());
      wd.z = COORD_W'($urandom());
      wd.u = u;
      wd.v = v;
      pending_words = {pending_words, wd};
   endtask

   task automatic queue_patch_burst(int prow, int pcol);
      for (int k = 0; k < 16; k++) queue_load(prow, pcol, k / 4, k % 4,
                                             rand_coord(), rand_coord(), rand_coord());
   endtask

   // global parameter that lands in patch i of n
   function automatic logic [PARAM_W-1:0] param_for(int i, int n);
      int lo;
      int hi;
      lo = (i == 0) ? 0 : (i * 65536) / n + 1;
      hi = ((i + 1) * 65536) / n;
      case ($urandom_range(0, 5))
         0: return PARAM_W'(lo);
         1: return PARAM_W'(hi);
         2: begin
            if (i == n - 1) return PARAM_W'($urandom_range(65536, 131071));
            return PARAM_W'($urandom_range(lo, hi));
         end
         default: return PARAM_W'($urandom_range(lo, hi));
      endcase
   endfunction

   task automatic fill_phase(int count);
      int done;
      int pr;
      int pc;
      int sel;
      int full[$];
      done = 0;
      while (done < count) begin
         full = {};
         for (int p = 0; p < GRID * GRID; p++)
            if (p / GRID < gen_count && p % GRID < gen_count && gen_fill[p] == 16)
               full = {full, p};
         sel = $urandom_range(0, 99);
         if (sel < 10 || (sel >= 40 && full.size() == 0)) begin
            queue_patch_burst($urandom_range(0, gen_count - 1), $urandom_range(0, gen_count - 1));
            done += 16;
         end else if (sel < 40) begin
            queue_load($urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1),
                       $urandom_range(0, 3), $urandom_range(0, 3),
                       rand_coord(), rand_coord(), rand_coord());
            done++;
         end else begin
            sel = full[$urandom_range(0, full.size() - 1)];
            pr = sel / GRID;
            pc = sel % GRID;
            queue_eval(param_for(pc, gen_count), param_for(pr, gen_count));
            done++;
         end
      end
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_words.size() > 0 || req_valid || expected_points.size() > 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_count(logic [COUNT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_patch_count <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      model_count = value;
      gen_count = effective_count(value);
   endtask

   initial begin
      logic [COUNT_W-1:0] counts[6];
      counts = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int k = 0; k < 16; k++) queue_load(0, 0, k / 4, k % 4, COORD_MAX, COORD_MIN, 24'sd0);
      queue_eval(17'd0, 17'd0);
      queue_eval(ONE_Q16, ONE_Q16);
      queue_eval(17'h1FFFF, 17'd0);
      queue_eval(17'd32768, 17'd32768);
      queue_eval(17'h10001, 17'd1);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         send_idle_pct = (ph < 2) ? 15 : (ph < 4) ? 79 : 0;
         recv_idle_pct = (ph < 2) ? 79 : (ph < 4) ? 15 : 0;
         write_count(counts[ph]);
         @(negedge clock);
         fill_phase(ITEMS_PER_PHASE);
         drain();
      end
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire
